// File: src/hurp_pkg.sv
package hurp_pkg;

  localparam int CORDIC_ITERS = 30;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADAR_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADAR_SCALE = 1'b1;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } delta_t;

endpackage

// File: src/heading_up_radar_projection_core.sv
// Heading-up radar projection.
// Input channel (in_valid/in_ready): one transaction carries target and viewer
// x/z positions (signed, FRAC_BITS fraction bits) and the viewer heading as a
// binary angle. Output channel (out_valid/out_ready): one transaction per input,
// the clamped pixel position radar_x/radar_y, in input order.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes the
// radar size, index 1 the scale (Q8.8, zero acts as one LSB). Write only idle.
// Pipeline: one capture stage, thirty CORDIC stages for sine and cosine, fold,
// multiply, sum, magnitude, then one restoring divider stage per quotient bit
// (41 - FRAC_BITS) and the output register. One transaction is accepted every
// cycle while the output flows.
// Reset clears every valid bit and loads size 256, scale 1152.
// When the receiver stalls with a result held, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module heading_up_radar_projection_core
  import hurp_pkg::*;
#(
  parameter int FRAC_BITS   = 8,
  parameter int ANGLE_BITS  = 16,
  parameter int EDGE_MARGIN = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_target_x,
  input  logic signed [31:0]   in_target_z,
  input  logic signed [31:0]   in_viewer_x,
  input  logic signed [31:0]   in_viewer_z,
  input  logic [15:0]          in_heading,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [11:0]          out_radar_x,
  output logic [11:0]          out_radar_y,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam int SH = 30 + FRAC_BITS - 8;
  localparam int TW = 63 - SH;
  localparam int PW = TW + 2;
  localparam logic [11:0] EM12 = 12'(EDGE_MARGIN);
  localparam logic signed [PW-1:0] EM_P = PW'(EDGE_MARGIN);

  logic [11:0] radar_size_r;
  logic [15:0] radar_scale_r;
  logic        en;

  logic signed [32:0] dy_w;
  logic signed [32:0] dx_w;
  delta_t             d_in;
  logic [31:0]        ang;

  logic               cv;
  delta_t             cdl;
  logic signed [31:0] ccos;
  logic signed [31:0] csin;

  logic               mv_r;
  logic signed [63:0] p_dxs_r;
  logic signed [63:0] p_dyc_r;
  logic signed [63:0] p_dxc_r;
  logic signed [63:0] p_dys_r;

  logic               sv_r;
  logic signed [63:0] xr_r;
  logic signed [63:0] yr_r;

  logic               av_r;
  logic [TW-1:0]      xm_r;
  logic [TW-1:0]      ym_r;
  logic               xn_r;
  logic               yn_r;
  logic [63:0]        xabs;
  logic [63:0]        yabs;

  logic [15:0]        den;
  logic               dxv;
  logic               dyv;
  logic [TW-1:0]      xq;
  logic [TW-1:0]      yq;
  logic               xqn;
  logic               yqn;

  logic signed [PW-1:0] qx;
  logic signed [PW-1:0] qy;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [PW-1:0] size_p;
  logic [11:0]          rx_nxt;
  logic [11:0]          ry_nxt;

  logic        out_valid_r;
  logic [11:0] out_radar_x_r;
  logic [11:0] out_radar_y_r;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radar_size_r  <= 12'd256;
      radar_scale_r <= 16'd1152;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADAR_SIZE:  radar_size_r  <= cfg_wdata[11:0];
        CFG_RADAR_SCALE: radar_scale_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign dy_w     = {in_target_x[31], in_target_x} - {in_viewer_x[31], in_viewer_x};
  assign dx_w     = {in_target_z[31], in_target_z} - {in_viewer_z[31], in_viewer_z};
  assign d_in.dx  = sat32(dx_w);
  assign d_in.dy  = sat32(dy_w);
  assign ang      = 32'(in_heading) << (32 - ANGLE_BITS);

  hurp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .in_delta  (d_in),
    .in_z      (zval_t'({3'b000, ang[29:0]})),
    .in_quad   (ang[31:30]),
    .out_valid (cv),
    .out_delta (cdl),
    .out_cos   (ccos),
    .out_sin   (csin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      sv_r <= 1'b0;
      av_r <= 1'b0;
    end else if (en) begin
      mv_r <= cv;
      sv_r <= mv_r;
      av_r <= sv_r;
    end
  end

  assign xabs = xr_r[63] ? 64'(-xr_r) : 64'(xr_r);
  assign yabs = yr_r[63] ? 64'(-yr_r) : 64'(yr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_dxs_r <= cdl.dx * csin;
      p_dyc_r <= cdl.dy * ccos;
      p_dxc_r <= cdl.dx * ccos;
      p_dys_r <= cdl.dy * csin;
      xr_r    <= p_dxs_r - p_dyc_r;
      yr_r    <= -(p_dxc_r + p_dys_r);
      xm_r    <= xabs[62:SH];
      ym_r    <= yabs[62:SH];
      xn_r    <= xr_r[63];
      yn_r    <= yr_r[63];
    end
  end

  assign den = (radar_scale_r == 16'd0) ? 16'd1 : radar_scale_r;

  hurp_div #(.DW(TW)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (av_r),
    .in_num    (xm_r),
    .in_neg    (xn_r),
    .in_den    (den),
    .out_valid (dxv),
    .out_quo   (xq),
    .out_neg   (xqn)
  );

  hurp_div #(.DW(TW)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (av_r),
    .in_num    (ym_r),
    .in_neg    (yn_r),
    .in_den    (den),
    .out_valid (dyv),
    .out_quo   (yq),
    .out_neg   (yqn)
  );

  assign size_p = signed'(PW'(radar_size_r));
  assign qx     = xqn ? -signed'(PW'(xq)) : signed'(PW'(xq));
  assign qy     = yqn ? -signed'(PW'(yq)) : signed'(PW'(yq));
  assign px     = signed'(PW'(radar_size_r >> 1)) + qx;
  assign py     = signed'(PW'(radar_size_r >> 1)) + qy;

  always_comb begin
    if (px > size_p) begin
      rx_nxt = (radar_size_r < EM12) ? 12'd0 : radar_size_r - EM12;
    end else if (px < EM_P) begin
      rx_nxt = EM12;
    end else begin
      rx_nxt = px[11:0];
    end
    if (py > size_p) begin
      ry_nxt = radar_size_r;
    end else if (py < EM_P) begin
      ry_nxt = 12'd0;
    end else begin
      ry_nxt = py[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dxv && dyv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_radar_x_r <= rx_nxt;
      out_radar_y_r <= ry_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_radar_x = out_radar_x_r;
  assign out_radar_y = out_radar_y_r;

endmodule

// File: src/hurp_cordic.sv
module hurp_cordic
  import hurp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  delta_t             in_delta,
  input  zval_t              in_z,
  input  logic [1:0]         in_quad,
  output logic               out_valid,
  output delta_t             out_delta,
  output logic signed [31:0] out_cos,
  output logic signed [31:0] out_sin
);

  logic   v_r     [CORDIC_ITERS+1];
  cval_t  x_r     [CORDIC_ITERS+1];
  cval_t  y_r     [CORDIC_ITERS+1];
  zval_t  z_r     [CORDIC_ITERS+1];
  logic [1:0] quad_r [CORDIC_ITERS+1];
  delta_t dl_r    [CORDIC_ITERS+1];

  logic               fv_r;
  delta_t             fdl_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;
  cval_t              c_nxt;
  cval_t              s_nxt;

  function automatic logic signed [31:0] sat_unit(input cval_t v);
    if (v > cval_t'(ONE_Q30)) begin
      return ONE_Q30;
    end else if (v < -cval_t'(ONE_Q30)) begin
      return -ONE_Q30;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= cval_t'({2'b00, CORDIC_GAIN});
      y_r[0]    <= '0;
      z_r[0]    <= in_z;
      quad_r[0] <= in_quad;
      dl_r[0]   <= in_delta;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    cval_t xs;
    cval_t ys;
    zval_t at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = zval_t'({1'b0, ATAN_TURNS[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        quad_r[i+1] <= quad_r[i];
        dl_r[i+1]   <= dl_r[i];
      end
    end
  end

  always_comb begin
    case (quad_r[CORDIC_ITERS])
      2'd0: begin
        c_nxt = x_r[CORDIC_ITERS];
        s_nxt = y_r[CORDIC_ITERS];
      end
      2'd1: begin
        c_nxt = -y_r[CORDIC_ITERS];
        s_nxt = x_r[CORDIC_ITERS];
      end
      2'd2: begin
        c_nxt = -x_r[CORDIC_ITERS];
        s_nxt = -y_r[CORDIC_ITERS];
      end
      default: begin
        c_nxt = y_r[CORDIC_ITERS];
        s_nxt = -x_r[CORDIC_ITERS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= v_r[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= sat_unit(c_nxt);
      sin_r <= sat_unit(s_nxt);
      fdl_r <= dl_r[CORDIC_ITERS];
    end
  end

  assign out_valid = fv_r;
  assign out_delta = fdl_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

endmodule

// File: src/hurp_div.sv
module hurp_div
  import hurp_pkg::*;
#(
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic          in_neg,
  input  logic [15:0]   in_den,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic          out_neg
);

  logic          v_r   [DW];
  logic [15:0]   rem_r [DW];
  logic [DW-1:0] nq_r  [DW];
  logic          neg_r [DW];

  logic          src_v   [DW];
  logic [15:0]   src_rem [DW];
  logic [DW-1:0] src_nq  [DW];
  logic          src_neg [DW];

  assign src_v[0]   = in_valid;
  assign src_rem[0] = '0;
  assign src_nq[0]  = in_num;
  assign src_neg[0] = in_neg;

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [16:0] trial;
    logic        ge;

    if (k > 0) begin : g_link
      assign src_v[k]   = v_r[k-1];
      assign src_rem[k] = rem_r[k-1];
      assign src_nq[k]  = nq_r[k-1];
      assign src_neg[k] = neg_r[k-1];
    end

    assign trial = {src_rem[k], src_nq[k][DW-1]};
    assign ge    = trial >= {1'b0, in_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 16'(trial - {1'b0, in_den}) : trial[15:0];
        nq_r[k]  <= {src_nq[k][DW-2:0], ge};
        neg_r[k] <= src_neg[k];
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_quo   = nq_r[DW-1];
  assign out_neg   = neg_r[DW-1];

endmodule

// File: src/hurp_checker.sv
module hurp_checker
  import hurp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [11:0]          out_radar_x,
  input logic [11:0]          out_radar_y,
  input logic                 cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_radar_x) && $stable(out_radar_y))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration channel not ready");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heading_up_radar_projection_core hurp_checker u_hurp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_radar_x (out_radar_x),
  .out_radar_y (out_radar_y),
  .cfg_ready   (cfg_ready)
);
